### sv/pbc_pkg.sv
// Shared constants and result codes for the polarimetric beam correction core.
// Used by the core, its pipelined divider and the port checker. No dependencies.
package pbc_pkg;

  localparam int QW            = 32;  // one real or imaginary part
  localparam int CW            = 64;  // one packed complex value
  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SINGULAR  = 2'd1,
    ST_ZERO_NORM = 2'd2,
    ST_SATURATED = 2'd3
  } status_t;

endpackage

### sv/pbc_div.sv
// Pipelined restoring divider: (a * 2^SH) / m, one quotient bit per stage,
// sign applied and saturated to the 32-bit range at the end. Uses pbc_pkg.
module pbc_div #(
  parameter int SH = 2 * pbc_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [pbc_pkg::QW-1:0]     a_i,
  input  logic                       neg_i,
  input  logic [pbc_pkg::CW-1:0]     m_i,
  output logic signed [pbc_pkg::QW-1:0] q_o,
  output logic                       sat_o
);
  import pbc_pkg::*;

  localparam int W = QW + SH;
  localparam logic [QW-1:0] LIM_POS = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] LIM_NEG = {1'b1, {(QW-1){1'b0}}};

  logic [CW-1:0] rem_r [W];
  logic [CW-1:0] m_r   [W];
  logic [QW-1:0] a_r   [W];
  logic [QW-1:0] q_r   [W];
  logic          ovf_r [W];
  logic          neg_r [W];

  for (genvar g = 0; g < W; g++) begin : g_stage
    logic [CW-1:0] rem_p, m_p, rem_nxt;
    logic [QW-1:0] a_p, q_p;
    logic          ovf_p, neg_p, ge;
    logic [CW:0]   trial;

    if (g == 0) begin : g_head
      assign rem_p = '0;
      assign m_p   = m_i;
      assign a_p   = a_i;
      assign q_p   = '0;
      assign ovf_p = 1'b0;
      assign neg_p = neg_i;
    end else begin : g_body
      assign rem_p = rem_r[g-1];
      assign m_p   = m_r[g-1];
      assign a_p   = a_r[g-1];
      assign q_p   = q_r[g-1];
      assign ovf_p = ovf_r[g-1];
      assign neg_p = neg_r[g-1];
    end

    // dividend bits come from the top of a; zeros shift in behind them
    assign trial   = {rem_p, a_p[QW-1]};
    assign ge      = trial >= {1'b0, m_p};
    assign rem_nxt = ge ? CW'(trial - {1'b0, m_p}) : trial[CW-1:0];

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= rem_nxt;
        m_r[g]   <= m_p;
        a_r[g]   <= {a_p[QW-2:0], 1'b0};
        q_r[g]   <= {q_p[QW-2:0], ge};
        ovf_r[g] <= ovf_p | q_p[QW-1];
        neg_r[g] <= neg_p;
      end
    end
  end

  logic [QW-1:0] lim, mag;

  always_comb begin
    lim   = neg_r[W-1] ? LIM_NEG : LIM_POS;
    sat_o = ovf_r[W-1] || (q_r[W-1] > lim);
    mag   = sat_o ? lim : q_r[W-1];
    q_o   = neg_r[W-1] ? signed'(QW'(-mag)) : signed'(mag);
  end

endmodule

### sv/polarimetric_beam_correction_core.sv
// Top level of the polarimetric beam correction core: Jones matrix inverses,
// matrix products and Stokes I normalization. Uses pbc_pkg and pbc_div.
//
// Each beat carries a measured 2x2 complex matrix V and beam matrices L and R;
// the core returns inv(L) * V * inv(R^H) (output_mode 0) or normalized Stokes I
// (output_mode 1) with a status code. It takes one beat per clock while
// in_tready is high and returns one result per beat in order. Most of the
// pipeline is the two bit-per-stage divider chains (inverse determinant, then
// norm). A two-entry output buffer keeps in_tready high until its skid entry
// fills; the whole pipeline then holds until the skid entry drains.
// Write cfg_data only while no beat is in flight.
module polarimetric_beam_correction_core #(
  parameter int FRAC_BITS = pbc_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // val_xx, val_yx, val_xy, val_yy, left_xx .. left_yy, right_xx .. right_yy
  input  logic [12*pbc_pkg::CW-1:0]   in_tdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // out_xx, out_yx, out_xy, out_yy
  output logic [4*pbc_pkg::CW-1:0]    out_tdata,
  // status
  output logic [1:0]                  out_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [0:0]                  cfg_data
);
  import pbc_pkg::*;

  localparam int PW  = CW - FRAC_BITS;        // rounded product width
  localparam int SH1 = 2 * FRAC_BITS;
  localparam int SH2 = FRAC_BITS + 1;
  localparam int W1  = QW + SH1;
  localparam int W2  = QW + SH2;
  localparam int NST = 11 + W1 + W2;

  typedef struct packed {
    logic signed [QW-1:0] re;
    logic signed [QW-1:0] im;
  } cpx_t;

  typedef struct packed {
    cpx_t xx;
    cpx_t yx;
    cpx_t xy;
    cpx_t yy;
  } mat_t;

  typedef struct packed {
    logic signed [PW-1:0] p0;
    logic signed [PW-1:0] p1;
    logic signed [PW-1:0] p2;
    logic signed [PW-1:0] p3;
    logic signed [PW-1:0] p4;
    logic signed [PW-1:0] p5;
    logic signed [PW-1:0] p6;
    logic signed [PW-1:0] p7;
  } pd_t;

  typedef struct packed {
    pd_t xx;
    pd_t yx;
    pd_t xy;
    pd_t yy;
  } mpd_t;

  typedef struct packed {
    logic                 sat;
    logic signed [QW-1:0] v;
  } cl_t;

  typedef struct packed {
    logic sat;
    cpx_t v;
  } csum_t;

  typedef struct packed {
    logic sat;
    mat_t m;
  } msum_t;

  typedef struct packed {
    mat_t v;
    mat_t l;
    mat_t r;
    logic sat;
    logic sing;
  } side1_t;

  typedef struct packed {
    mat_t c;
    logic sat;
    logic sing;
    logic zn;
  } side2_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [4*CW-1:0] data;
  } res_t;

  function automatic logic signed [PW-1:0] qmul(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
    logic signed [CW-1:0] p;
    p = CW'(a) * CW'(b);
    p = p + (64'sd1 <<< (FRAC_BITS - 1));
    return PW'(p >>> FRAC_BITS);
  endfunction

  function automatic cl_t clamp32(input logic signed [CW-1:0] x);
    cl_t r;
    if (x > 64'sd2147483647) begin
      r.sat = 1'b1;
      r.v   = 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      r.sat = 1'b1;
      r.v   = 32'sh80000000;
    end else begin
      r.sat = 1'b0;
      r.v   = x[QW-1:0];
    end
    return r;
  endfunction

  function automatic cl_t neg32(input logic signed [QW-1:0] x);
    return clamp32(-CW'(x));
  endfunction

  function automatic logic [QW-1:0] mag32(input logic signed [QW-1:0] x);
    return x[QW-1] ? QW'(-x) : QW'(x);
  endfunction

  function automatic logic [QW:0] abs33(input logic signed [QW-1:0] x);
    return x[QW-1] ? (33'd0 - 33'(x)) : 33'(x);
  endfunction

  // products of a*b + c*d, each rounded
  function automatic pd_t dot_prod(input cpx_t a, input cpx_t b,
                                   input cpx_t c, input cpx_t d);
    pd_t p;
    p.p0 = qmul(a.re, b.re);
    p.p1 = qmul(a.im, b.im);
    p.p2 = qmul(c.re, d.re);
    p.p3 = qmul(c.im, d.im);
    p.p4 = qmul(a.re, b.im);
    p.p5 = qmul(a.im, b.re);
    p.p6 = qmul(c.re, d.im);
    p.p7 = qmul(c.im, d.re);
    return p;
  endfunction

  // a*b + c*d or a*b - c*d, one clamp per part
  function automatic csum_t dot_sum(input pd_t p, input logic sub);
    logic signed [CW-1:0] re1, re2, im1, im2;
    cl_t   cr, ci;
    csum_t r;
    re1  = CW'(p.p0) - CW'(p.p1);
    re2  = CW'(p.p2) - CW'(p.p3);
    im1  = CW'(p.p4) + CW'(p.p5);
    im2  = CW'(p.p6) + CW'(p.p7);
    cr   = clamp32(sub ? re1 - re2 : re1 + re2);
    ci   = clamp32(sub ? im1 - im2 : im1 + im2);
    r.v.re = cr.v;
    r.v.im = ci.v;
    r.sat  = cr.sat | ci.sat;
    return r;
  endfunction

  function automatic mpd_t mm_prod(input mat_t a, input mat_t b);
    mpd_t r;
    r.xx = dot_prod(a.xx, b.xx, a.xy, b.yx);
    r.yx = dot_prod(a.yx, b.xx, a.yy, b.yx);
    r.xy = dot_prod(a.xx, b.xy, a.xy, b.yy);
    r.yy = dot_prod(a.yx, b.xy, a.yy, b.yy);
    return r;
  endfunction

  function automatic msum_t mm_sum(input mpd_t p);
    csum_t a, b, c, d;
    msum_t r;
    a = dot_sum(p.xx, 1'b0);
    b = dot_sum(p.yx, 1'b0);
    c = dot_sum(p.xy, 1'b0);
    d = dot_sum(p.yy, 1'b0);
    r.m.xx = a.v;
    r.m.yx = b.v;
    r.m.xy = c.v;
    r.m.yy = d.v;
    r.sat  = a.sat | b.sat | c.sat | d.sat;
    return r;
  endfunction

  // adjugate times the scaled reciprocal of the determinant
  function automatic mpd_t inv_prod(input mat_t a, input cpx_t f, input cpx_t nf);
    mpd_t r;
    r.xx = dot_prod(a.yy, f,  '0, '0);
    r.yy = dot_prod(a.xx, f,  '0, '0);
    r.yx = dot_prod(a.yx, nf, '0, '0);
    r.xy = dot_prod(a.xy, nf, '0, '0);
    return r;
  endfunction

  // ---------------------------------------------------------------- control
  logic            mode_r;
  logic            en;
  logic            push;
  logic [NST-1:0]  vld_r;
  logic            out_valid_r, skid_valid_r;
  res_t            out_res_r, skid_res_r, res_nxt;

  assign cfg_ready = 1'b1;
  assign en        = !skid_valid_r;
  assign in_tready = en;
  assign push      = en && vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_valid) begin
      mode_r <= cfg_data[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_tvalid};
    end
  end

  // ---------------------------------------------------------------- stage 1
  mat_t  v_in, l_in, r_in, rh_in;
  logic  sat_in;
  cl_t   n0, n1, n2, n3;

  always_comb begin
    v_in.xx = in_tdata[0*CW +: CW];
    v_in.yx = in_tdata[1*CW +: CW];
    v_in.xy = in_tdata[2*CW +: CW];
    v_in.yy = in_tdata[3*CW +: CW];
    l_in.xx = in_tdata[4*CW +: CW];
    l_in.yx = in_tdata[5*CW +: CW];
    l_in.xy = in_tdata[6*CW +: CW];
    l_in.yy = in_tdata[7*CW +: CW];
    r_in.xx = in_tdata[8*CW +: CW];
    r_in.yx = in_tdata[9*CW +: CW];
    r_in.xy = in_tdata[10*CW +: CW];
    r_in.yy = in_tdata[11*CW +: CW];
    // conjugate transpose of the right beam
    n0 = neg32(r_in.xx.im);
    n1 = neg32(r_in.xy.im);
    n2 = neg32(r_in.yx.im);
    n3 = neg32(r_in.yy.im);
    rh_in.xx = '{re: r_in.xx.re, im: n0.v};
    rh_in.yx = '{re: r_in.xy.re, im: n1.v};
    rh_in.xy = '{re: r_in.yx.re, im: n2.v};
    rh_in.yy = '{re: r_in.yy.re, im: n3.v};
    sat_in = n0.sat | n1.sat | n2.sat | n3.sat;
  end

  mat_t v1_r, l1_r, r1_r;
  logic sat1_r;
  mat_t v2_r, l2_r, r2_r;
  logic sat2_r;
  pd_t  pdl2_r, pdr2_r;
  mat_t v3_r, l3_r, r3_r;
  logic sat3_r;
  cpx_t dl3_r, dr3_r;
  mat_t v4_r, l4_r, r4_r;
  logic sat4_r;
  cpx_t dl4_r, dr4_r;
  logic [CW-1:0] sqlre4_r, sqlim4_r, sqrre4_r, sqrim4_r;
  mat_t v5_r, l5_r, r5_r;
  logic sat5_r, sing5_r;
  cpx_t dl5_r, dr5_r;
  logic [CW-1:0] ml5_r, mr5_r;
  csum_t dl_sum, dr_sum;

  assign dl_sum = dot_sum(pdl2_r, 1'b1);
  assign dr_sum = dot_sum(pdr2_r, 1'b1);

  always_ff @(posedge clk) begin
    if (en) begin
      v1_r   <= v_in;
      l1_r   <= l_in;
      r1_r   <= rh_in;
      sat1_r <= sat_in;

      // determinant products
      v2_r   <= v1_r;
      l2_r   <= l1_r;
      r2_r   <= r1_r;
      sat2_r <= sat1_r;
      pdl2_r <= dot_prod(l1_r.xx, l1_r.yy, l1_r.xy, l1_r.yx);
      pdr2_r <= dot_prod(r1_r.xx, r1_r.yy, r1_r.xy, r1_r.yx);

      v3_r   <= v2_r;
      l3_r   <= l2_r;
      r3_r   <= r2_r;
      sat3_r <= sat2_r | dl_sum.sat | dr_sum.sat;
      dl3_r  <= dl_sum.v;
      dr3_r  <= dr_sum.v;

      // squared magnitude of each determinant
      v4_r     <= v3_r;
      l4_r     <= l3_r;
      r4_r     <= r3_r;
      sat4_r   <= sat3_r;
      dl4_r    <= dl3_r;
      dr4_r    <= dr3_r;
      sqlre4_r <= unsigned'(CW'(dl3_r.re) * CW'(dl3_r.re));
      sqlim4_r <= unsigned'(CW'(dl3_r.im) * CW'(dl3_r.im));
      sqrre4_r <= unsigned'(CW'(dr3_r.re) * CW'(dr3_r.re));
      sqrim4_r <= unsigned'(CW'(dr3_r.im) * CW'(dr3_r.im));

      v5_r    <= v4_r;
      l5_r    <= l4_r;
      r5_r    <= r4_r;
      sat5_r  <= sat4_r;
      dl5_r   <= dl4_r;
      dr5_r   <= dr4_r;
      ml5_r   <= sqlre4_r + sqlim4_r;
      mr5_r   <= sqrre4_r + sqrim4_r;
      sing5_r <= ((sqlre4_r + sqlim4_r) == '0) || ((sqrre4_r + sqrim4_r) == '0);
    end
  end

  // ---------------------------------------------------------- determinant division
  side1_t d1_r [W1];
  logic signed [QW-1:0] flre, flim, frre, frim;
  logic                 sflre, sflim, sfrre, sfrim;

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r[0] <= '{v: v5_r, l: l5_r, r: r5_r, sat: sat5_r, sing: sing5_r};
      for (int k = 1; k < W1; k++) begin
        d1_r[k] <= d1_r[k-1];
      end
    end
  end

  pbc_div #(.SH(SH1)) u_div_lre (
    .clk(clk), .en(en), .a_i(mag32(dl5_r.re)), .neg_i(dl5_r.re < 0),
    .m_i(ml5_r), .q_o(flre), .sat_o(sflre));
  pbc_div #(.SH(SH1)) u_div_lim (
    .clk(clk), .en(en), .a_i(mag32(dl5_r.im)), .neg_i(dl5_r.im > 0),
    .m_i(ml5_r), .q_o(flim), .sat_o(sflim));
  pbc_div #(.SH(SH1)) u_div_rre (
    .clk(clk), .en(en), .a_i(mag32(dr5_r.re)), .neg_i(dr5_r.re < 0),
    .m_i(mr5_r), .q_o(frre), .sat_o(sfrre));
  pbc_div #(.SH(SH1)) u_div_rim (
    .clk(clk), .en(en), .a_i(mag32(dr5_r.im)), .neg_i(dr5_r.im > 0),
    .m_i(mr5_r), .q_o(frim), .sat_o(sfrim));

  // ---------------------------------------------------------------- inverses
  cpx_t fl, fr, nfl, nfr;
  cl_t  c0, c1, c2, c3;
  logic sat_f;

  always_comb begin
    fl  = '{re: flre, im: flim};
    fr  = '{re: frre, im: frim};
    c0  = neg32(flre);
    c1  = neg32(flim);
    c2  = neg32(frre);
    c3  = neg32(frim);
    nfl = '{re: c0.v, im: c1.v};
    nfr = '{re: c2.v, im: c3.v};
    sat_f = sflre | sflim | sfrre | sfrim | c0.sat | c1.sat | c2.sat | c3.sat;
  end

  mat_t  v6_r;
  logic  sat6_r, sing6_r;
  mpd_t  pil6_r, pir6_r;
  mat_t  v7_r, li7_r, ri7_r;
  logic  sat7_r, sing7_r;
  logic  sat8_r, sing8_r;
  mat_t  ri8_r;
  mpd_t  pt8_r, pp8_r;
  logic  sat9_r, satp9_r, sing9_r;
  mat_t  ri9_r, t9_r, p9_r;
  logic  sat10_r, satp10_r, sing10_r;
  mpd_t  pc10_r;
  logic [QW+2:0] s10_r, s11_r;
  logic  sat11_r, sing11_r;
  mat_t  c11_r;
  msum_t li_sum, ri_sum, t_sum, p_sum, c_sum;
  logic [QW+2:0] s_nxt;

  assign li_sum = mm_sum(pil6_r);
  assign ri_sum = mm_sum(pir6_r);
  assign t_sum  = mm_sum(pt8_r);
  assign p_sum  = mm_sum(pp8_r);
  assign c_sum  = mm_sum(pc10_r);

  always_comb begin
    s_nxt = 35'(abs33(p9_r.xx.re)) + 35'(abs33(p9_r.xx.im))
          + 35'(abs33(p9_r.yx.re)) + 35'(abs33(p9_r.yx.im))
          + 35'(abs33(p9_r.xy.re)) + 35'(abs33(p9_r.xy.im))
          + 35'(abs33(p9_r.yy.re)) + 35'(abs33(p9_r.yy.im));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v6_r    <= d1_r[W1-1].v;
      sat6_r  <= d1_r[W1-1].sat | sat_f;
      sing6_r <= d1_r[W1-1].sing;
      pil6_r  <= inv_prod(d1_r[W1-1].l, fl, nfl);
      pir6_r  <= inv_prod(d1_r[W1-1].r, fr, nfr);

      v7_r    <= v6_r;
      li7_r   <= li_sum.m;
      ri7_r   <= ri_sum.m;
      sat7_r  <= sat6_r | li_sum.sat | ri_sum.sat;
      sing7_r <= sing6_r;

      // inv(L) * V and the trace matrix inv(R^H) * inv(L)
      sat8_r  <= sat7_r;
      sing8_r <= sing7_r;
      ri8_r   <= ri7_r;
      pt8_r   <= mm_prod(li7_r, v7_r);
      pp8_r   <= mm_prod(ri7_r, li7_r);

      sat9_r  <= sat8_r | t_sum.sat;
      satp9_r <= p_sum.sat;
      sing9_r <= sing8_r;
      ri9_r   <= ri8_r;
      t9_r    <= t_sum.m;
      p9_r    <= p_sum.m;

      sat10_r  <= sat9_r;
      satp10_r <= satp9_r;
      sing10_r <= sing9_r;
      pc10_r   <= mm_prod(t9_r, ri9_r);
      s10_r    <= s_nxt;

      // trace clamps count only when the norm is used
      sat11_r  <= sat10_r | c_sum.sat | (mode_r & satp10_r);
      sing11_r <= sing10_r;
      c11_r    <= c_sum.m;
      s11_r    <= s10_r;
    end
  end

  // ---------------------------------------------------------------- norm division
  side2_t d2_r [W2];
  logic signed [QW-1:0] axr, axi, ayr, ayi;
  logic                 saxr, saxi, sayr, sayi;

  always_ff @(posedge clk) begin
    if (en) begin
      d2_r[0] <= '{c: c11_r, sat: sat11_r, sing: sing11_r, zn: s11_r == '0};
      for (int k = 1; k < W2; k++) begin
        d2_r[k] <= d2_r[k-1];
      end
    end
  end

  pbc_div #(.SH(SH2)) u_div_xre (
    .clk(clk), .en(en), .a_i(mag32(c11_r.xx.re)), .neg_i(c11_r.xx.re < 0),
    .m_i(CW'(s11_r)), .q_o(axr), .sat_o(saxr));
  pbc_div #(.SH(SH2)) u_div_xim (
    .clk(clk), .en(en), .a_i(mag32(c11_r.xx.im)), .neg_i(c11_r.xx.im < 0),
    .m_i(CW'(s11_r)), .q_o(axi), .sat_o(saxi));
  pbc_div #(.SH(SH2)) u_div_yre (
    .clk(clk), .en(en), .a_i(mag32(c11_r.yy.re)), .neg_i(c11_r.yy.re < 0),
    .m_i(CW'(s11_r)), .q_o(ayr), .sat_o(sayr));
  pbc_div #(.SH(SH2)) u_div_yim (
    .clk(clk), .en(en), .a_i(mag32(c11_r.yy.im)), .neg_i(c11_r.yy.im < 0),
    .m_i(CW'(s11_r)), .q_o(ayi), .sat_o(sayi));

  // ---------------------------------------------------------------- result
  side2_t               fin;
  logic signed [QW:0]   sum_re, sum_im;
  cpx_t                 stokes;
  logic                 sat_stokes;

  always_comb begin
    fin        = d2_r[W2-1];
    sum_re     = 33'(axr) + 33'(ayr);
    sum_im     = 33'(axi) + 33'(ayi);
    stokes.re  = QW'(sum_re >>> 1);
    stokes.im  = QW'(sum_im >>> 1);
    sat_stokes = fin.sat | saxr | saxi | sayr | sayi;
    if (fin.sing) begin
      res_nxt.status = ST_SINGULAR;
      res_nxt.data   = '0;
    end else if (!mode_r) begin
      res_nxt.status = fin.sat ? ST_SATURATED : ST_OK;
      res_nxt.data   = {fin.c.yy, fin.c.xy, fin.c.yx, fin.c.xx};
    end else if (fin.zn) begin
      res_nxt.status = ST_ZERO_NORM;
      res_nxt.data   = '0;
    end else begin
      res_nxt.status = sat_stokes ? ST_SATURATED : ST_OK;
      res_nxt.data   = {{(3*CW){1'b0}}, stokes};
    end
  end

  // output register plus one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_res_r <= skid_valid_r ? skid_res_r : res_nxt;
    end else if (push) begin
      skid_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.data;
  assign out_tuser  = out_res_r.status;

endmodule

### sv/pbc_checker.sv
// Port-level checks for the polarimetric beam correction core, bound to it below.
// Uses pbc_pkg for the status codes.
module pbc_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic [12*pbc_pkg::CW-1:0] in_tdata,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic [4*pbc_pkg::CW-1:0]  out_tdata,
  input logic [1:0]                out_tuser,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic                      cfg_valid,
  input logic                      cfg_ready,
  input logic [0:0]                cfg_data
);
  import pbc_pkg::*;

  // reset empties the output side
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat valid right after reset");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_SINGULAR |-> out_tdata == '0)
    else $error("singular result carries nonzero data");

  a_zero_norm_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_ZERO_NORM |-> out_tdata == '0)
    else $error("zero-norm result carries nonzero data");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result beat changed");

endmodule

bind polarimetric_beam_correction_core pbc_checker u_pbc_checker (.*);

### dv/tb.sv
// Self-checking bench for polarimetric_beam_correction_core: Jones inverse,
// matrix products and Stokes I normalization checked beat by beat.
// Depends on pbc_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb;
  import pbc_pkg::*;

  localparam int  FB    = FRAC_BITS_DEF;
  localparam int  LIMIT = 400000;
  localparam bit  MODE_LINEAR = 1'b0;
  localparam bit  MODE_STOKES = 1'b1;

  localparam logic [63:0] ONE  = 64'h00010000_00000000;
  localparam logic [63:0] HALF = 64'h00008000_00000000;
  localparam logic [63:0] MAXC = 64'h7fffffff_7fffffff;
  localparam logic [63:0] MINC = 64'h80000000_80000000;
  localparam logic [63:0] ONES = 64'hffffffff_ffffffff;

  typedef struct packed { longint re; longint im; } cx_t;
  typedef struct packed { cx_t xx; cx_t yx; cx_t xy; cx_t yy; } mat_t;
  typedef struct packed { logic [4*CW-1:0] d; status_t st; } corr_t;
  typedef struct packed {
    bit              mode;
    logic [12*CW-1:0] d;
    bit              chk;
    logic [4*CW-1:0] eo;
    status_t         es;
  } vec_t;

  logic                clk, rst_n;
  logic [12*CW-1:0]    in_tdata;
  logic                in_tvalid, in_tready;
  logic [4*CW-1:0]     out_tdata;
  logic [1:0]          out_tuser;
  logic                out_tvalid, out_tready;
  logic                cfg_valid, cfg_ready;
  logic [0:0]          cfg_data;

  polarimetric_beam_correction_core #(.FRAC_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  bit     cur_mode;
  bit     clamp_hit;
  corr_t  corr_q[$];
  int     errors;
  int     cyc;
  int     snd_idle, rcv_idle;
  int     stall_left;
  vec_t   dir_rows[$];

  // ---------------- predictor ----------------
  function automatic longint sat(longint x);
    if (x > 64'sd2147483647) begin clamp_hit = 1; return 64'sd2147483647; end
    if (x < -64'sd2147483648) begin clamp_hit = 1; return -64'sd2147483648; end
    return x;
  endfunction

  function automatic longint qm(longint a, longint b);
    return (a * b + (64'sd1 <<< (FB - 1))) >>> FB;
  endfunction

  function automatic cx_t cdot(cx_t a, cx_t b, cx_t c, cx_t d);
    cx_t r;
    r.re = sat(qm(a.re, b.re) - qm(a.im, b.im) + qm(c.re, d.re) - qm(c.im, d.im));
    r.im = sat(qm(a.re, b.im) + qm(a.im, b.re) + qm(c.re, d.im) + qm(c.im, d.re));
    return r;
  endfunction

  function automatic cx_t cmul(cx_t a, cx_t b);
    return cdot(a, b, '0, '0);
  endfunction

  function automatic longint divq(longint n, int sh, longint unsigned m);
    longint unsigned a, r, q, lim;
    bit ovf, b;
    int pos;
    a = (n < 0) ? -n : n;
    r = 0; q = 0; ovf = 0;
    for (int i = 32 + sh; i > 0; i--) begin
      pos = i - 1;
      b = (pos >= sh) ? a[pos - sh] : 1'b0;
      r = {r[62:0], b};
      if (!ovf) begin
        q = q << 1;
        if ((q >> 32) != 0) ovf = 1;
      end
      if (r >= m) begin
        r = r - m;
        if (!ovf) q[0] = 1'b1;
      end
    end
    lim = (n < 0) ? 64'h80000000 : 64'h7fffffff;
    if (ovf || q > lim) begin
      clamp_hit = 1;
      q = lim;
    end
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic mat_t jones_inv(mat_t a, inout bit sing);
    mat_t r;
    cx_t dt, f, nf;
    longint unsigned m;
    r = '0;
    dt.re = sat(qm(a.xx.re, a.yy.re) - qm(a.xx.im, a.yy.im)
              - qm(a.xy.re, a.yx.re) + qm(a.xy.im, a.yx.im));
    dt.im = sat(qm(a.xx.re, a.yy.im) + qm(a.xx.im, a.yy.re)
              - qm(a.xy.re, a.yx.im) - qm(a.xy.im, a.yx.re));
    m = longint'(dt.re * dt.re) + longint'(dt.im * dt.im);
    if (m == 0) begin
      sing = 1;
      return r;
    end
    f.re  = divq(dt.re, 2 * FB, m);
    f.im  = divq(-dt.im, 2 * FB, m);
    nf.re = sat(-f.re);
    nf.im = sat(-f.im);
    r.xx = cmul(a.yy, f);
    r.yy = cmul(a.xx, f);
    r.yx = cmul(a.yx, nf);
    r.xy = cmul(a.xy, nf);
    return r;
  endfunction

  function automatic mat_t mat_mul(mat_t a, mat_t b);
    mat_t c;
    c.xx = cdot(a.xx, b.xx, a.xy, b.yx);
    c.yx = cdot(a.yx, b.xx, a.yy, b.yx);
    c.xy = cdot(a.xx, b.xy, a.xy, b.yy);
    c.yy = cdot(a.yx, b.xy, a.yy, b.yy);
    return c;
  endfunction

  function automatic cx_t unpk(logic [63:0] v);
    cx_t c;
    c.re = $signed(v[63:32]);
    c.im = $signed(v[31:0]);
    return c;
  endfunction

  function automatic mat_t ld(logic [12*CW-1:0] d, int base);
    mat_t m;
    m.xx = unpk(d[(base + 0) * CW +: CW]);
    m.yx = unpk(d[(base + 1) * CW +: CW]);
    m.xy = unpk(d[(base + 2) * CW +: CW]);
    m.yy = unpk(d[(base + 3) * CW +: CW]);
    return m;
  endfunction

  function automatic logic [63:0] pk(cx_t c);
    return {c.re[31:0], c.im[31:0]};
  endfunction

  function automatic longint absl(longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic corr_t correct_beat(logic [12*CW-1:0] d, bit mode);
    mat_t v, l, r, li, ri, c, p;
    cx_t t, a, b, st;
    bit sing;
    longint s;
    corr_t res;
    clamp_hit = 0;
    sing = 0;
    res = '0;
    v = ld(d, 0); l = ld(d, 4); r = ld(d, 8);
    // conjugate transpose of the right beam
    t = r.xy; r.xy = r.yx; r.yx = t;
    r.xx.im = sat(-r.xx.im);
    r.yx.im = sat(-r.yx.im);
    r.xy.im = sat(-r.xy.im);
    r.yy.im = sat(-r.yy.im);
    li = jones_inv(l, sing);
    ri = jones_inv(r, sing);
    if (sing) begin
      res.st = ST_SINGULAR;
      return res;
    end
    c = mat_mul(mat_mul(li, v), ri);
    if (mode == MODE_LINEAR) begin
      res.d = {pk(c.yy), pk(c.xy), pk(c.yx), pk(c.xx)};
    end else begin
      p = mat_mul(ri, li);
      s = absl(p.xx.re) + absl(p.xx.im) + absl(p.yx.re) + absl(p.yx.im)
        + absl(p.xy.re) + absl(p.xy.im) + absl(p.yy.re) + absl(p.yy.im);
      if (s == 0) begin
        res.st = ST_ZERO_NORM;
        return res;
      end
      a.re = divq(c.xx.re, FB + 1, s);
      a.im = divq(c.xx.im, FB + 1, s);
      b.re = divq(c.yy.re, FB + 1, s);
      b.im = divq(c.yy.im, FB + 1, s);
      st.re = (a.re + b.re) >>> 1;
      st.im = (a.im + b.im) >>> 1;
      res.d[CW-1:0] = pk(st);
    end
    res.st = clamp_hit ? ST_SATURATED : ST_OK;
    return res;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic logic [4*CW-1:0] mat(logic [63:0] xx, logic [63:0] yx,
                                         logic [63:0] xy, logic [63:0] yy);
    return {yy, xy, yx, xx};
  endfunction

  function automatic void row(bit mode, logic [4*CW-1:0] v, logic [4*CW-1:0] l,
                              logic [4*CW-1:0] r, bit chk, logic [4*CW-1:0] eo,
                              status_t es);
    vec_t e;
    e.mode = mode; e.d = {r, l, v}; e.chk = chk; e.eo = eo; e.es = es;
    dir_rows.push_back(e);
  endfunction

  function automatic logic [63:0] mod_part();
    logic [31:0] a, b;
    a = $urandom_range(0, 262144) - 131072;
    b = $urandom_range(0, 262144) - 131072;
    return {a, b};
  endfunction

  function automatic logic [12*CW-1:0] rnd_beat();
    logic [12*CW-1:0] d;
    int k, sel;
    logic [31:0] big;
    k = $urandom_range(0, 9);
    for (int i = 0; i < 12; i++)
      d[i*CW +: CW] = (k == 6) ? {$urandom, $urandom} : mod_part();
    case (k)
      7: begin
        // rank-one beam: second row copies the first
        sel = $urandom_range(0, 1) ? 4 : 8;
        d[(sel + 1) * CW +: CW] = d[sel * CW +: CW];
        d[(sel + 3) * CW +: CW] = d[(sel + 2) * CW +: CW];
      end
      8: begin
        // tiny left beam, full-range value: drive saturation
        for (int i = 4; i < 8; i++)
          d[i*CW +: CW] = {32'($urandom_range(0, 512) - 256),
                           32'($urandom_range(0, 512) - 256)};
        for (int i = 0; i < 4; i++) d[i*CW +: CW] = {$urandom, $urandom};
      end
      9: begin
        // large diagonal beams: tiny inverses, push the norm toward zero
        for (int i = 4; i < 12; i++) begin
          big = 32'h00b50000 + $urandom_range(0, 65535);
          d[i*CW +: CW] = (i % 4 == 0 || i % 4 == 3) ?
                          {big, ($urandom_range(0, 1) ? big : 32'h0)} : 64'h0;
        end
      end
      default: ;
    endcase
    return d;
  endfunction

  // ---------------- clock, timeout ----------------
  initial clk = 0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // ---------------- scoreboard ----------------
  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cyc);
    errors++;
  endtask

  always @(posedge clk) begin
    corr_t e;
    if (rst_n && in_tvalid && in_tready)
      corr_q.push_back(correct_beat(in_tdata, cur_mode));
    if (rst_n && out_tvalid && out_tready) begin
      if (corr_q.size() == 0) begin
        report("unexpected beat", out_tdata[63:0], 64'h0);
      end else begin
        e = corr_q.pop_front();
        for (int i = 0; i < 4; i++)
          if (out_tdata[i*CW +: CW] !== e.d[i*CW +: CW])
            report($sformatf("out entry %0d", i), out_tdata[i*CW +: CW],
                   e.d[i*CW +: CW]);
        if (out_tuser !== e.st) report("status", out_tuser, e.st);
      end
    end
  end

  // receiver: random backpressure plus a long hold-off on request
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  // ---------------- drivers ----------------
  task automatic send_beat(logic [12*CW-1:0] d);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    // let the scoreboard log the last accepted beat first
    @(posedge clk);
    while (corr_q.size() != 0) @(posedge clk);
    repeat (140) @(posedge clk);
  endtask

  task automatic set_mode(bit m);
    in_tvalid <= 1'b0;
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_mode = m;
  endtask

  initial begin
    logic [4*CW-1:0] id, zm;
    corr_t got;
    rst_n = 0; in_tvalid = 0; in_tdata = '0; out_tready = 0;
    cfg_valid = 0; cfg_data = '0;
    cur_mode = MODE_LINEAR; errors = 0; cyc = 0; stall_left = 0;
    snd_idle = 33; rcv_idle = 87;

    id = mat(ONE, 64'h0, 64'h0, ONE);
    zm = '0;
    row(MODE_LINEAR, mat(ONES, ONES, ONES, ONES), zm, zm, 1, '0, ST_SINGULAR);
    row(MODE_LINEAR, mat(MAXC, MINC, ONE, ONES), id, id, 1,
        mat(MAXC, MINC, ONE, ONES), ST_OK);
    row(MODE_LINEAR, mat(ONE, HALF, MAXC, MINC), id, mat(ONE, ONE, ONE, ONE), 1,
        '0, ST_SINGULAR);
    row(MODE_LINEAR, mat(ONE, HALF, ONE, HALF), mat(ONES, ONES, ONES, ONES), id,
        0, '0, ST_OK);
    row(MODE_LINEAR, mat(MAXC, MINC, MAXC, MINC), mat(HALF, 0, 0, HALF), id,
        0, '0, ST_OK);
    row(MODE_LINEAR, mat(MINC, MINC, MAXC, MAXC), mat(MINC, MAXC, MAXC, MINC),
        mat(MAXC, MINC, MINC, MAXC), 0, '0, ST_OK);
    row(MODE_LINEAR, mat(64'h00030000_fffe8000, HALF, 64'h0000c000_00004000, ONE),
        mat(64'h00020000_00010000, 64'h00008000_0, 64'hffff0000_0, ONE),
        mat(ONE, 64'h0_00010000, 64'h0_ffff0000, 64'h00020000_0), 0, '0, ST_OK);
    row(MODE_STOKES, id, id, id, 1, mat(ONE, 64'h0, 64'h0, 64'h0), ST_OK);
    row(MODE_STOKES, id, zm, id, 1, '0, ST_SINGULAR);
    row(MODE_STOKES, mat(ONE, ONE, ONE, ONE),
        mat(64'h00b50000_00000000, 0, 0, 64'h00b50000_00b50000),
        mat(64'h00b50000_00b50000, 0, 0, 64'h00b50000_00000000), 0, '0, ST_OK);
    row(MODE_STOKES, mat(MAXC, MAXC, MAXC, MAXC), mat(HALF, 0, 0, HALF),
        mat(HALF, 0, 0, HALF), 0, '0, ST_OK);
    row(MODE_STOKES, mat(ONES, ONES, ONES, ONES), mat(ONES, 0, 0, ONES),
        mat(ONES, ONES, 0, ONES), 0, '0, ST_OK);
    row(MODE_STOKES, mat(MINC, MAXC, MINC, MAXC), id, id, 0, '0, ST_OK);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_mode(MODE_LINEAR);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode != cur_mode) set_mode(dir_rows[i].mode);
      if (dir_rows[i].chk) begin
        got.d = dir_rows[i].eo;
        got.st = dir_rows[i].es;
        if (correct_beat(dir_rows[i].d, cur_mode) != got)
          report($sformatf("table row %0d", i), 64'h0, 64'h0);
      end
      send_beat(dir_rows[i].d);
    end

    for (int ch = 0; ch < 6; ch++) begin
      set_mode(ch[0]);
      case (ch / 2)
        0: begin snd_idle = 33; rcv_idle = 87; end
        1: begin snd_idle = 87; rcv_idle = 33; end
        default: begin snd_idle = 0; rcv_idle = 0; end
      endcase
      // long hold-off: offer more beats than the pipeline holds
      if (ch == 4) stall_left = 500;
      for (int n = 0; n < ((ch == 4) ? 200 : (ch == 5) ? 50 : 125); n++)
        send_beat(rnd_beat());
    end
    in_tvalid <= 1'b0;
    drain();

    if (errors == 0 && corr_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
sv/pbc_pkg.sv
sv/pbc_div.sv
sv/polarimetric_beam_correction_core.sv
sv/pbc_checker.sv
dv/tb.sv
